### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### rtl/fpa_pkg.sv
`timescale 1ns / 1ps
package fpa_pkg;

  // Raw operand and result width
  localparam int unsigned DataW = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_GT  = 4'd4,
    OP_LT  = 4'd5,
    OP_GE  = 4'd6,
    OP_LE  = 4'd7,
    OP_EQ  = 4'd8,
    OP_NE  = 4'd9,
    OP_MIN = 4'd10,
    OP_MAX = 4'd11,
    OP_INC = 4'd12,
    OP_DEC = 4'd13,
    OP_INT = 4'd14
  } opcode_e;

  // Which back-end path finishes the transaction
  typedef enum logic [1:0] {
    CLS_DIRECT = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } op_class_e;

  typedef logic signed [DataW-1:0] word_t;

  typedef struct packed {
    logic [3:0] opcode;
    word_t      operand_a;
    word_t      operand_b;
  } alu_req_t;

  typedef struct packed {
    word_t result_value;
    logic  compare_true;
    logic  divide_by_zero;
  } alu_rsp_t;

  // Classified transaction held between front and back
  typedef struct packed {
    op_class_e op_class;
    word_t     operand_a;
    word_t     operand_b;
    alu_rsp_t  direct;
  } queue_entry_t;

endpackage

### rtl/fixed_point_alu.sv
`timescale 1ns / 1ps
// Path of a result: queue, execute register, divider stages, output register.
// Throughput: one transaction per cycle while the output is not stalled; the divider is a
// pipeline of 32 + FRAC_BITS compare-subtract stages, which also carry the 32x32 product.
// The queue between classifier and execution pipeline holds QUEUE_DEPTH transactions.
// Reset (asynchronous, active low) empties the queue and clears all valid flags.
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS   = 8,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fpa_pkg::alu_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fpa_pkg::alu_rsp_t out_data_o
);
  import fpa_pkg::*;

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;
  queue_entry_t q_wr_entry;
  queue_entry_t q_rd_entry;

  fpa_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_wr_entry)
  );

  fpa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .valid_o (q_valid)
  );

  fpa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_rd_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/fpa_front.sv
`timescale 1ns / 1ps
module fpa_front #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fpa_pkg::alu_req_t     in_data_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output fpa_pkg::queue_entry_t q_entry_o
);
  import fpa_pkg::*;

  word_t        a;
  word_t        b;
  logic         a_lt_b;
  logic         a_eq_b;
  queue_entry_t entry;

  assign a      = in_data_i.operand_a;
  assign b      = in_data_i.operand_b;
  assign a_lt_b = a < b;
  assign a_eq_b = a == b;

  // Accept whenever the queue has room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify; everything but multiply and divide by a nonzero divisor is finished here
  always_comb begin
    entry           = '0;
    entry.op_class  = CLS_DIRECT;
    entry.operand_a = a;
    entry.operand_b = b;
    case (in_data_i.opcode)
      OP_ADD: entry.direct.result_value = a + b;
      OP_SUB: entry.direct.result_value = a - b;
      OP_MUL: entry.op_class = CLS_MUL;
      OP_DIV: begin
        // zero divisor: result stays zero, flag set
        if (b == '0) begin
          entry.direct.divide_by_zero = 1'b1;
        end else begin
          entry.op_class = CLS_DIV;
        end
      end
      OP_GT:  entry.direct.compare_true = !a_lt_b && !a_eq_b;
      OP_LT:  entry.direct.compare_true = a_lt_b;
      OP_GE:  entry.direct.compare_true = !a_lt_b;
      OP_LE:  entry.direct.compare_true = a_lt_b || a_eq_b;
      OP_EQ:  entry.direct.compare_true = a_eq_b;
      OP_NE:  entry.direct.compare_true = !a_eq_b;
      OP_MIN: entry.direct.result_value = a_lt_b ? a : b;
      OP_MAX: entry.direct.result_value = a_lt_b ? b : a;
      OP_INC: entry.direct.result_value = a + 32'sd1;
      OP_DEC: entry.direct.result_value = a - 32'sd1;
      OP_INT: entry.direct.result_value = a >>> FRAC_BITS;
      default: begin
      end
    endcase
  end

  assign q_entry_o = entry;

endmodule

### rtl/fpa_queue.sv
`timescale 1ns / 1ps
module fpa_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  fpa_pkg::queue_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output fpa_pkg::queue_entry_t entry_o,
  output logic                  valid_o
);
  import fpa_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  queue_entry_t    slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  assign full_o  = count_q == CntW'(DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = slot_q[rd_ptr_q];

endmodule

### rtl/fpa_back.sv
`timescale 1ns / 1ps
module fpa_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  fpa_pkg::queue_entry_t q_entry_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fpa_pkg::alu_rsp_t     out_data_o
);
  import fpa_pkg::*;

  localparam int unsigned NumW  = DataW + FRAC_BITS;
  localparam int unsigned ProdW = 2 * DataW;

  typedef struct packed {
    op_class_e        op_class;
    alu_rsp_t         rsp;
    logic [NumW-1:0]  num;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quot;
    logic [DataW-1:0] den;
    logic             neg;
  } div_stage_t;

  // One restoring-division step: one quotient bit
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t       r;
    logic [DataW:0]   part;
    logic [DataW:0]   diff;
    r     = s;
    part  = {s.rem, s.num[NumW-1]};
    diff  = part - {1'b0, s.den};
    r.num = s.num << 1;
    if (!diff[DataW]) begin
      r.rem  = diff[DataW-1:0];
      r.quot = {s.quot[DataW-2:0], 1'b1};
    end else begin
      r.rem  = part[DataW-1:0];
      r.quot = {s.quot[DataW-2:0], 1'b0};
    end
    return r;
  endfunction

  logic                    adv;
  logic                    out_valid_q;
  alu_rsp_t                out_data_q;
  alu_rsp_t                out_data_d;

  logic [DataW-1:0]        mag_a;
  logic [DataW-1:0]        mag_b;
  logic signed [ProdW-1:0] prod;

  logic                    ex_valid_q;
  op_class_e               ex_class_q;
  alu_rsp_t                ex_rsp_q;
  logic signed [ProdW-1:0] ex_prod_q;
  logic [NumW-1:0]         ex_num_q;
  logic [DataW-1:0]        ex_den_q;
  logic                    ex_neg_q;

  div_stage_t              first_src;
  div_stage_t              st_q [NumW];
  logic [NumW-1:0]         st_vld_q;
  div_stage_t              last;

  // Whole pipeline moves unless the output register is held
  assign adv     = !(out_valid_q && out_stall_i);
  assign q_pop_o = adv && q_valid_i;

  // Operand magnitudes and full product
  assign mag_a = q_entry_i.operand_a[DataW-1] ? DataW'(-q_entry_i.operand_a)
                                              : DataW'(q_entry_i.operand_a);
  assign mag_b = q_entry_i.operand_b[DataW-1] ? DataW'(-q_entry_i.operand_b)
                                              : DataW'(q_entry_i.operand_b);
  assign prod  = ProdW'(q_entry_i.operand_a) * ProdW'(q_entry_i.operand_b);

  // Execute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else if (adv) begin
      ex_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ex_class_q <= q_entry_i.op_class;
      ex_rsp_q   <= q_entry_i.direct;
      ex_prod_q  <= prod;
      ex_num_q   <= {mag_a, {FRAC_BITS{1'b0}}};
      ex_den_q   <= mag_b;
      ex_neg_q   <= q_entry_i.operand_a[DataW-1] ^ q_entry_i.operand_b[DataW-1];
    end
  end

  // Product scaling lands in the first divider stage
  always_comb begin
    first_src          = '0;
    first_src.op_class = ex_class_q;
    first_src.rsp      = ex_rsp_q;
    if (ex_class_q == CLS_MUL) begin
      first_src.rsp.result_value = ex_prod_q[FRAC_BITS +: DataW];
    end
    first_src.num      = ex_num_q;
    first_src.den      = ex_den_q;
    first_src.neg      = ex_neg_q;
  end

  // Divider pipeline, one stage per dividend bit
  for (genvar k = 0; k < NumW; k++) begin : g_stage
    div_stage_t src;
    logic       src_vld;

    if (k == 0) begin : g_first
      assign src     = first_src;
      assign src_vld = ex_valid_q;
    end else begin : g_next
      assign src     = st_q[k-1];
      assign src_vld = st_vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_vld_q[k] <= 1'b0;
      end else if (adv) begin
        st_vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k] <= div_step(src);
      end
    end
  end

  // Sign fix-up of the quotient
  assign last = st_q[NumW-1];

  always_comb begin
    out_data_d = last.rsp;
    if (last.op_class == CLS_DIV) begin
      out_data_d.result_value = last.neg ? -last.quot : last.quot;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= st_vld_q[NumW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/fpa_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fpa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input fpa_pkg::alu_rsp_t out_data_o
);

  // Held result stays put
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Queue only fills up after a transaction was taken
  `ASSERT_IMPL(a_stall_rise, clk_i, rst_ni, $rose(in_stall_o), $past(in_valid_i && !in_stall_o))

  // Flags are exclusive
  `ASSERT_IMPL(a_flags_excl, clk_i, rst_ni, out_valid_o, !(out_data_o.compare_true && out_data_o.divide_by_zero))

  // Compares carry a zero value
  `ASSERT_IMPL(a_cmp_zero, clk_i, rst_ni, out_valid_o && out_data_o.compare_true, out_data_o.result_value == '0)

  // Divide by zero carries a zero value
  `ASSERT_IMPL(a_dz_zero, clk_i, rst_ni, out_valid_o && out_data_o.divide_by_zero, out_data_o.result_value == '0)

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
